### rtl/core/rmq_pkg.sv
// Shared definitions for the rotation matrix to quaternion converter.
// Holds the default word format and the branch codes; depends on nothing.
`default_nettype none

package rmq_pkg;

	localparam int DEF_WORD_BITS = 18;
	localparam int DEF_FRAC_BITS = 16;

	// Which formula produced the quaternion.
	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_DIAG1 = 2'd1,
		BR_DIAG2 = 2'd2,
		BR_DIAG3 = 2'd3
	} branch_t;

endpackage

`default_nettype wire

### rtl/core/rotation_matrix_to_quaternion.sv
// Channel  Dir  Signals                        Contents
// -------  ---  -----------------------------  -------------------------------------------
// matrix   in   s_tvalid s_tready s_tdata      nine elements row1_col1 .. row3_col3
// quat     out  m_tvalid m_tready m_tdata      quat_x quat_y quat_z quat_w
//                          m_tuser             branch_taken, radicand_clamped
//
// One matrix transfer is accepted every cycle while the output register is empty or
// being read. A matrix passes ROOT_BITS + WORD_BITS + 3 register stages (39 with the
// default Q2.16 format): one front stage, one stage per root bit in the square-root
// pipe, a divider prep stage, one stage per quotient bit in the divider pipe, and the
// output register.
// The whole pipeline advances together whenever the output register is empty or
// being read, so a stall on m_tready freezes every stage and drops nothing.
// arst_n clears only the valid bits; data registers are not reset.
//
// Uses rmq_pkg, rmq_front, rmq_sqrt and rmq_div.
`default_nettype none

module rotation_matrix_to_quaternion #(
	parameter int WORD_BITS = rmq_pkg::DEF_WORD_BITS,
	parameter int FRAC_BITS = rmq_pkg::DEF_FRAC_BITS,
	localparam int IN_BYTES  = (9 * WORD_BITS + 7) / 8,
	localparam int OUT_BYTES = (4 * WORD_BITS + 7) / 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	// row1_col1, row1_col2, row1_col3, row2_col1, row2_col2, row2_col3,
	// row3_col1, row3_col2, row3_col3, then zero fill to a whole byte.
	input  wire logic [IN_BYTES*8-1:0]   s_tdata,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	// quat_x, quat_y, quat_z, quat_w, then zero fill to a whole byte.
	output logic [OUT_BYTES*8-1:0]       m_tdata,
	// branch_taken [1:0], radicand_clamped [2].
	output logic [2:0]                   m_tuser
);

	localparam int W         = WORD_BITS;
	localparam int RW        = ((WORD_BITS > FRAC_BITS) ? WORD_BITS : FRAC_BITS + 1) + 3;
	localparam int RB        = RW - 1;
	localparam int SW        = (RB + FRAC_BITS + 1) / 2;
	localparam int STAG      = 3 + 3 + 3 * (W + 1);
	localparam int DTAG      = 3 + 3 + SW;
	localparam int HW        = (SW - 1 > W) ? SW - 1 : W;

	// The pipeline moves as one when the output register can take a new item.
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// Front stage.
	logic                     f_valid;
	logic [RB-1:0]            f_rad;
	rmq_pkg::branch_t         f_br;
	logic                     f_clamp;
	logic [3*(W+1)-1:0]       f_mag;
	logic [2:0]               f_neg;

	rmq_front #(
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (s_tvalid),
		.in_mat   (s_tdata[9*W-1:0]),
		.valid_s1 (f_valid),
		.rad_s1   (f_rad),
		.br_s1    (f_br),
		.clamp_s1 (f_clamp),
		.mag_s1   (f_mag),
		.neg_s1   (f_neg)
	);

	// Square-root pipe; branch, clamp flag, signs and magnitudes ride along.
	logic               r_valid;
	logic [SW-1:0]      r_root;
	logic [STAG-1:0]    r_tag;

	rmq_sqrt #(
		.RAD_BITS  (RB),
		.FRAC_BITS (FRAC_BITS),
		.TAG_BITS  (STAG),
		.ROOT_BITS (SW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (f_valid),
		.in_rad    (f_rad),
		.in_tag    ({f_mag, f_neg, f_clamp, f_br}),
		.out_valid (r_valid),
		.out_root  (r_root),
		.out_tag   (r_tag)
	);

	// Divider pipe; the root itself rides along for the half-root component.
	logic               d_valid;
	logic [3*W-1:0]     d_quo;
	logic [2:0]         d_ovf;
	logic [DTAG-1:0]    d_tag;

	rmq_div #(
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS),
		.ROOT_BITS (SW),
		.TAG_BITS  (DTAG)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (r_valid),
		.in_root   (r_root),
		.in_mag    (r_tag[STAG-1:6]),
		.in_tag    ({r_root, r_tag[5:0]}),
		.out_valid (d_valid),
		.out_quo   (d_quo),
		.out_ovf   (d_ovf),
		.out_tag   (d_tag)
	);

	// Saturation and placement of the half root into its component slot.
	rmq_pkg::branch_t   o_br;
	logic               o_clamp;
	logic [2:0]         o_neg;
	logic [W-1:0]       wmax, wmin;
	logic [W-1:0]       v [3];
	logic [W-1:0]       q;
	logic [HW-1:0]      half_x;
	logic [W-1:0]       half;
	logic [W-1:0]       qx, qy, qz, qw;

	always_comb begin
		o_br    = rmq_pkg::branch_t'(d_tag[1:0]);
		o_clamp = d_tag[2];
		o_neg   = d_tag[5:3];
		wmax    = {1'b0, {(W-1){1'b1}}};
		wmin    = {1'b1, {(W-1){1'b0}}};
		for (int i = 0; i < 3; i++) begin
			q = d_quo[i*W +: W];
			if (!o_neg[i]) begin
				v[i] = (d_ovf[i] || q[W-1]) ? wmax : q;
			end else begin
				v[i] = (d_ovf[i] || (q[W-1] && |q[W-2:0])) ? wmin : (~q + 1'b1);
			end
		end
		half_x = HW'(d_tag[DTAG-1:7]);
		half   = (half_x > HW'(wmax)) ? wmax : half_x[W-1:0];
		unique case (o_br)
			rmq_pkg::BR_TRACE: begin
				qx = v[0]; qy = v[1]; qz = v[2]; qw = half;
			end
			rmq_pkg::BR_DIAG1: begin
				qx = half; qy = v[0]; qz = v[1]; qw = v[2];
			end
			rmq_pkg::BR_DIAG2: begin
				qx = v[0]; qy = half; qz = v[1]; qw = v[2];
			end
			default: begin
				qx = v[0]; qy = v[1]; qz = half; qw = v[2];
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= (OUT_BYTES*8)'({qw, qz, qy, qx});
			m_tuser <= {o_clamp, o_br};
		end
	end

endmodule

`default_nettype wire

### rtl/core/rmq_front.sv
// Front stage: trace, branch choice, radicand and the three off-diagonal terms.
// Uses rmq_pkg for the branch codes.
`default_nettype none

module rmq_front #(
	parameter int WORD_BITS = rmq_pkg::DEF_WORD_BITS,
	parameter int FRAC_BITS = rmq_pkg::DEF_FRAC_BITS,
	localparam int RW = ((WORD_BITS > FRAC_BITS) ? WORD_BITS : FRAC_BITS + 1) + 3,
	localparam int RB = RW - 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       adv,
	input  wire logic                       in_valid,
	input  wire logic [9*WORD_BITS-1:0]     in_mat,
	output logic                            valid_s1,
	output logic [RB-1:0]                   rad_s1,
	output rmq_pkg::branch_t                br_s1,
	output logic                            clamp_s1,
	output logic [3*(WORD_BITS+1)-1:0]      mag_s1,
	output logic [2:0]                      neg_s1
);

	localparam int W  = WORD_BITS;

	logic signed [W-1:0]  m [9];
	logic signed [RW-1:0] e11, e22, e33, one, tr, rad;
	logic signed [W:0]    a12, a13, a21, a23, a31, a32;
	logic signed [W:0]    d [3];
	logic [W:0]           mag [3];
	rmq_pkg::branch_t     br;
	logic                 clamp;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			m[i] = in_mat[i*W +: W];
		end
		e11 = {{(RW-W){m[0][W-1]}}, m[0]};
		e22 = {{(RW-W){m[4][W-1]}}, m[4]};
		e33 = {{(RW-W){m[8][W-1]}}, m[8]};
		one = {{(RW-1){1'b0}}, 1'b1} << FRAC_BITS;
		tr  = e11 + e22 + e33;
		// A tie with the first diagonal element favors it; a tie between the second and third favors the third.
		if (tr > 0) begin
			br  = rmq_pkg::BR_TRACE;
			rad = tr + one;
		end else if (m[0] >= m[4] && m[0] >= m[8]) begin
			br  = rmq_pkg::BR_DIAG1;
			rad = one + e11 - e22 - e33;
		end else if (m[4] > m[8]) begin
			br  = rmq_pkg::BR_DIAG2;
			rad = one + e22 - e11 - e33;
		end else begin
			br  = rmq_pkg::BR_DIAG3;
			rad = one + e33 - e11 - e22;
		end
		clamp = (rad <= 0);

		a12 = {m[1][W-1], m[1]};
		a13 = {m[2][W-1], m[2]};
		a21 = {m[3][W-1], m[3]};
		a23 = {m[5][W-1], m[5]};
		a31 = {m[6][W-1], m[6]};
		a32 = {m[7][W-1], m[7]};
		// The three terms in x, y, z, w order with the half-root slot skipped.
		unique case (br)
			rmq_pkg::BR_TRACE: begin
				d[0] = a23 - a32; d[1] = a31 - a13; d[2] = a12 - a21;
			end
			rmq_pkg::BR_DIAG1: begin
				d[0] = a12 + a21; d[1] = a13 + a31; d[2] = a23 - a32;
			end
			rmq_pkg::BR_DIAG2: begin
				d[0] = a21 + a12; d[1] = a32 + a23; d[2] = a31 - a13;
			end
			default: begin
				d[0] = a31 + a13; d[1] = a32 + a23; d[2] = a12 - a21;
			end
		endcase
		for (int i = 0; i < 3; i++) begin
			mag[i] = d[i][W] ? (~d[i] + 1'b1) : d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s1   <= clamp ? RB'(1) : rad[RB-1:0];
			br_s1    <= br;
			clamp_s1 <= clamp;
			for (int i = 0; i < 3; i++) begin
				mag_s1[i*(W+1) +: W+1] <= mag[i];
				neg_s1[i]              <= d[i][W];
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/rmq_sqrt.sv
// Pipelined integer square root of (radicand << FRAC_BITS), one root bit per stage.
// Carries a side tag alongside; takes its default format from rmq_pkg.
`default_nettype none

module rmq_sqrt #(
	parameter int RAD_BITS  = 20,
	parameter int FRAC_BITS = rmq_pkg::DEF_FRAC_BITS,
	parameter int TAG_BITS  = 8,
	parameter int ROOT_BITS = (RAD_BITS + FRAC_BITS + 1) / 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic                 in_valid,
	input  wire logic [RAD_BITS-1:0]  in_rad,
	input  wire logic [TAG_BITS-1:0]  in_tag,
	output logic                      out_valid,
	output logic [ROOT_BITS-1:0]      out_root,
	output logic [TAG_BITS-1:0]       out_tag
);

	localparam int SW = ROOT_BITS;
	localparam int NE = 2 * SW;

	logic [NE-1:0]       n_s    [SW+1];
	logic [SW+1:0]       rem_s  [SW+1];
	logic [SW-1:0]       root_s [SW+1];
	logic                v_s    [SW+1];
	logic [TAG_BITS-1:0] tag_s  [SW+1];

	always_comb begin
		n_s[0]    = NE'(in_rad) << FRAC_BITS;
		rem_s[0]  = '0;
		root_s[0] = '0;
		v_s[0]    = in_valid;
		tag_s[0]  = in_tag;
	end

	for (genvar k = 0; k < SW; k++) begin : g_stage
		logic [SW+1:0] rem_sh, trial, rem_nx;
		logic          ge;

		always_comb begin
			rem_sh = {rem_s[k][SW-1:0], n_s[k][NE-1:NE-2]};
			trial  = {root_s[k], 2'b01};
			ge     = (rem_sh >= trial);
			rem_nx = ge ? (rem_sh - trial) : rem_sh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				n_s[k+1]    <= n_s[k] << 2;
				rem_s[k+1]  <= rem_nx;
				root_s[k+1] <= {root_s[k][SW-2:0], ge};
				tag_s[k+1]  <= tag_s[k];
			end
		end
	end

	assign out_valid = v_s[SW];
	assign out_root  = root_s[SW];
	assign out_tag   = tag_s[SW];

endmodule

`default_nettype wire

### rtl/core/rmq_div.sv
// Three-lane pipelined divider: q = (mag << FRAC_BITS + s) / (2 s), one quotient bit
// per stage, with an overflow flag for quotients that need more than WORD_BITS bits.
`default_nettype none

module rmq_div #(
	parameter int WORD_BITS = rmq_pkg::DEF_WORD_BITS,
	parameter int FRAC_BITS = rmq_pkg::DEF_FRAC_BITS,
	parameter int ROOT_BITS = 18,
	parameter int TAG_BITS  = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         adv,
	input  wire logic                         in_valid,
	input  wire logic [ROOT_BITS-1:0]         in_root,
	input  wire logic [3*(WORD_BITS+1)-1:0]   in_mag,
	input  wire logic [TAG_BITS-1:0]          in_tag,
	output logic                              out_valid,
	output logic [3*WORD_BITS-1:0]            out_quo,
	output logic [2:0]                        out_ovf,
	output logic [TAG_BITS-1:0]               out_tag
);

	localparam int W  = WORD_BITS;
	localparam int NB = WORD_BITS + FRAC_BITS + 2;
	localparam int DB = ROOT_BITS + 1;
	localparam int CW = (NB > DB + W) ? NB : DB + W;

	logic [CW-1:0]       rem_s [W+1][3];
	logic [W-1:0]        quo_s [W+1][3];
	logic [2:0]          ovf_s [W+1];
	logic [DB-1:0]       dvs_s [W+1];
	logic                v_s   [W+1];
	logic [TAG_BITS-1:0] tag_s [W+1];

	// Prep stage: rounding bias, divisor and overflow check.
	logic [CW-1:0] num  [3];
	logic [CW-1:0] dtop;

	always_comb begin
		dtop = CW'({in_root, 1'b0}) << W;
		for (int i = 0; i < 3; i++) begin
			num[i] = CW'((NB'(in_mag[i*(W+1) +: W+1]) << FRAC_BITS) + NB'(in_root));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dvs_s[0] <= {in_root, 1'b0};
			tag_s[0] <= in_tag;
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i] <= num[i];
				quo_s[0][i] <= '0;
				ovf_s[0][i] <= (num[i] >= dtop);
			end
		end
	end

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [CW-1:0] trial;
		logic [2:0]    ge;

		always_comb begin
			trial = CW'(dvs_s[k]) << (W - 1 - k);
			for (int i = 0; i < 3; i++) begin
				ge[i] = (rem_s[k][i] >= trial);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dvs_s[k+1] <= dvs_s[k];
				tag_s[k+1] <= tag_s[k];
				ovf_s[k+1] <= ovf_s[k];
				for (int i = 0; i < 3; i++) begin
					rem_s[k+1][i] <= ge[i] ? (rem_s[k][i] - trial) : rem_s[k][i];
					quo_s[k+1][i] <= quo_s[k][i] | (W'(ge[i]) << (W - 1 - k));
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			out_quo[i*W +: W] = quo_s[W][i];
		end
	end

	assign out_valid = v_s[W];
	assign out_ovf   = ovf_s[W];
	assign out_tag   = tag_s[W];

endmodule

`default_nettype wire

### rtl/core/rmq_check.sv
// Port-level checks for rotation_matrix_to_quaternion, attached with bind.
// Uses rmq_pkg for the branch codes.
`default_nettype none

module rmq_check #(
	parameter int OUT_W = 72
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata,
	input wire logic [2:0]       m_tuser
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result transfer withdrawn while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output register state");

	a_trace_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == rmq_pkg::BR_TRACE) |-> !m_tuser[2])
		else $error("positive-trace result flagged as clamped");

	// Every valid bit in the pipe is cleared by arst_n, so nothing can be valid right after reset.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("output valid after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_check #(
	.OUT_W (OUT_BYTES * 8)
) u_rmq_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
